// File: hdl/bmpenc_pkg.sv
// ----------------------------------------------------------------------------
// bmpenc_pkg - shared types and constants of the bmp stream encoder
// Register codes, pixel modes, bmp header constants and the command item
// that passes from the front end to the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bmpenc_pkg;

	localparam int MAX_DIMENSION_DEF = 4096;

	localparam int COMP_W      = 8;
	localparam int CFG_DIM_W   = 13;
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int WORD_W      = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam int HDR_BYTES      = 54;
	localparam int INFO_BYTES     = 40;
	localparam int BITS_PER_PIXEL = 24;

	localparam logic [COMP_W-1:0] BMP_MAGIC_B = 8'h42;
	localparam logic [COMP_W-1:0] BMP_MAGIC_M = 8'h4D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_MODE   = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_RGB      = 2'd0,
		MODE_YUV420P  = 2'd1,
		MODE_YUVJ444P = 2'd2,
		MODE_NV12     = 2'd3
	} pixel_mode_t;

	typedef struct packed {
		logic              hdr;
		logic [WORD_W-1:0] file_size;
		logic [WORD_W-1:0] width_word;
		logic [WORD_W-1:0] height_word;
		logic [WORD_W-1:0] img_bytes;
		logic [COMP_W-1:0] blue;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] red;
		logic [1:0]        pad;
		logic              frame_done;
	} cmd_t;

endpackage

`default_nettype wire

// File: hdl/bmpenc_if.sv
// ----------------------------------------------------------------------------
// bmpenc_if - stream channels of the bmp stream encoder
// Pixel input, byte output and register write channels, each valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmpenc_pixel_if;
	logic                          valid;
	logic                          ready;
	logic [bmpenc_pkg::COMP_W-1:0] comp_a;
	logic [bmpenc_pkg::COMP_W-1:0] comp_b;
	logic [bmpenc_pkg::COMP_W-1:0] comp_c;

	modport source (output valid, output comp_a, output comp_b, output comp_c, input ready);
	modport sink (input valid, input comp_a, input comp_b, input comp_c, output ready);
endinterface

interface bmpenc_byte_if;
	logic                          valid;
	logic                          ready;
	logic [bmpenc_pkg::COMP_W-1:0] out_byte;
	logic                          run_last;
	logic                          frame_end;

	modport source (output valid, output out_byte, output run_last, output frame_end,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input frame_end,
		output ready);
endinterface

interface bmpenc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bmpenc_pkg::CFG_IDX_W-1:0]  index;
	logic [bmpenc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/yuv_to_rgb_bmp_stream_encoder_top.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_bmp_stream_encoder_top - 24-bit bmp stream encoder
// Turns a pixel stream into a bmp byte stream with optional yuv to rgb.
// ----------------------------------------------------------------------------
// pixel_in takes one pixel per item in bmp order, bottom row first, left to
// right. byte_out gives one byte of the file per item: 54 header bytes before
// the first pixel of a frame, then blue, green, red, then zero padding at the
// end of each row. run_last marks the end of a pixel's bytes and padding, frame_end the
// last byte of the file. cfg writes width (0), height (1) and pixel mode (2);
// it is always ready; the user must write it only while the encoder is idle,
// and the block itself does not enforce this. the first byte of a pixel passes
// both front-end stages, a queue entry, then the output register, and can stall.
// the output register emits one byte per cycle while byte_out.ready is high,
// so a pixel costs three bytes, plus its padding bytes and the 54-byte header run.
// the front end takes a pixel per cycle until the four-entry command queue
// and both front-end stages are full; then pixel_in.ready drops until the
// sequencer frees an entry.
// when byte_out.ready is low the output holds its byte and the queue backs up.
// reset sets width 1, height 1, rgb mode and starts a new file.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv_to_rgb_bmp_stream_encoder_top #(
	parameter int MAX_DIMENSION = bmpenc_pkg::MAX_DIMENSION_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	bmpenc_pixel_if.sink  pixel_in,
	bmpenc_cfg_if.sink    cfg,
	bmpenc_byte_if.source byte_out
);

	bmpenc_pkg::cmd_t cmd;
	bmpenc_pkg::cmd_t head;
	logic             cmd_valid;
	logic             full;
	logic             empty;
	logic             pop;

	bmpenc_front #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (pixel_in),
		.cfg       (cfg),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (!full)
	);

	bmpenc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_valid),
		.din    (cmd),
		.full   (full),
		.pop    (pop),
		.dout   (head),
		.empty  (empty)
	);

	bmpenc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.byte_out (byte_out)
	);

endmodule

`default_nettype wire

// File: hdl/bmpenc_front.sv
// ----------------------------------------------------------------------------
// bmpenc_front - pixel front end of the bmp stream encoder
// Holds the registers, tracks row and column, decides header and padding
// per pixel and converts yuv to rgb in two stages before the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpenc_front #(
	parameter int MAX_DIMENSION = bmpenc_pkg::MAX_DIMENSION_DEF
) (
	input  wire                     clk,
	input  wire                     arst_n,
	bmpenc_pixel_if.sink            pixel_in,
	bmpenc_cfg_if.sink              cfg,
	output bmpenc_pkg::cmd_t        cmd,
	output logic                    cmd_valid,
	input  wire                     cmd_ready
);

	localparam int DIM_W  = $clog2(MAX_DIMENSION + 1);
	localparam int RB_W   = DIM_W + 2;
	localparam int IMG_W  = RB_W + DIM_W;
	localparam int C_W    = bmpenc_pkg::COMP_W;
	localparam int PROD_W = 26;
	localparam int SUM_W  = 27;

	localparam logic signed [PROD_W-1:0] K_RV = PROD_W'(91881);
	localparam logic signed [PROD_W-1:0] K_GU = PROD_W'(22553);
	localparam logic signed [PROD_W-1:0] K_GV = PROD_W'(46802);
	localparam logic signed [PROD_W-1:0] K_BU = PROD_W'(116130);

	function automatic logic [DIM_W-1:0] eff_dim(input logic [bmpenc_pkg::CFG_DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIMENSION)) begin
			r = DIM_W'(MAX_DIMENSION);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	function automatic logic [C_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] s);
		logic [C_W-1:0] r;
		if (s < 0) begin
			r = '0;
		end else if (s[SUM_W-1:16] > (SUM_W-16)'(255)) begin
			r = '1;
		end else begin
			r = s[23:16];
		end
		return r;
	endfunction

	// registers
	logic [bmpenc_pkg::CFG_DIM_W-1:0] width_q;
	logic [bmpenc_pkg::CFG_DIM_W-1:0] height_q;
	bmpenc_pkg::pixel_mode_t          mode_q;

	// frame position
	logic [DIM_W-1:0] col_q;
	logic [DIM_W-1:0] row_q;
	logic             header_sent_q;

	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [DIM_W:0]   col_next;
	logic [DIM_W:0]   row_next;
	logic             row_end;
	logic             frame_done;
	logic [RB_W-1:0]  row_bytes;
	logic [IMG_W-1:0] img_full;
	logic             accept;
	logic             advance_s1;
	logic             advance_s2;

	logic signed [PROD_W-1:0] d_ext;
	logic signed [PROD_W-1:0] e_ext;

	// stage 1
	logic                     valid_s1;
	logic                     hdr_s1;
	logic                     done_s1;
	logic [1:0]               pad_s1;
	logic                     yuv_s1;
	logic [C_W-1:0]           a_s1;
	logic [C_W-1:0]           b_s1;
	logic [C_W-1:0]           c_s1;
	logic signed [PROD_W-1:0] prv_s1;
	logic signed [PROD_W-1:0] pgu_s1;
	logic signed [PROD_W-1:0] pgv_s1;
	logic signed [PROD_W-1:0] pbu_s1;
	logic [DIM_W-1:0]         w_s1;
	logic [DIM_W-1:0]         h_s1;
	logic [IMG_W-1:0]         img_s1;

	// stage 2
	logic                     valid_s2;
	bmpenc_pkg::cmd_t         cmd_s2;
	bmpenc_pkg::cmd_t         cmd_d;
	logic signed [SUM_W-1:0]  y_ext;
	logic signed [SUM_W-1:0]  sum_r;
	logic signed [SUM_W-1:0]  sum_g;
	logic signed [SUM_W-1:0]  sum_b;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bmpenc_pkg::CFG_DIM_W'(1);
			height_q <= bmpenc_pkg::CFG_DIM_W'(1);
			mode_q   <= bmpenc_pkg::MODE_RGB;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bmpenc_pkg::REG_WIDTH: begin
					width_q <= cfg.data[bmpenc_pkg::CFG_DIM_W-1:0];
				end
				bmpenc_pkg::REG_HEIGHT: begin
					height_q <= cfg.data[bmpenc_pkg::CFG_DIM_W-1:0];
				end
				bmpenc_pkg::REG_MODE: begin
					mode_q <= bmpenc_pkg::pixel_mode_t'(cfg.data[1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	assign advance_s2 = !valid_s2 || cmd_ready;
	assign advance_s1 = !valid_s1 || advance_s2;
	assign pixel_in.ready = advance_s1;
	assign accept = pixel_in.valid && advance_s1;

	assign w_eff      = eff_dim(width_q);
	assign h_eff      = eff_dim(height_q);
	assign col_next   = {1'b0, col_q} + (DIM_W+1)'(1);
	assign row_next   = {1'b0, row_q} + (DIM_W+1)'(1);
	assign row_end    = col_next >= {1'b0, w_eff};
	assign frame_done = row_end && (row_next >= {1'b0, h_eff});

	// row stride is 3*width rounded up to four bytes
	assign row_bytes = (RB_W'({w_eff, 1'b0}) + RB_W'(w_eff) + RB_W'(3)) & ~RB_W'(3);
	assign img_full  = IMG_W'(row_bytes) * IMG_W'(h_eff);

	// chroma minus 128 is the byte with its top bit flipped, as signed
	assign d_ext = PROD_W'(signed'({~pixel_in.comp_b[C_W-1], pixel_in.comp_b[C_W-2:0]}));
	assign e_ext = PROD_W'(signed'({~pixel_in.comp_c[C_W-1], pixel_in.comp_c[C_W-2:0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			header_sent_q <= 1'b0;
		end else if (accept) begin
			header_sent_q <= !frame_done;
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_done ? '0 : row_next[DIM_W-1:0];
			end else begin
				col_q <= col_next[DIM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hdr_s1 <= !header_sent_q;
			done_s1 <= frame_done;
			// padding bytes per row equal width mod 4
			pad_s1 <= row_end ? w_eff[1:0] : 2'd0;
			yuv_s1 <= mode_q != bmpenc_pkg::MODE_RGB;
			a_s1   <= pixel_in.comp_a;
			b_s1   <= pixel_in.comp_b;
			c_s1   <= pixel_in.comp_c;
			prv_s1 <= K_RV * e_ext;
			pgu_s1 <= K_GU * d_ext;
			pgv_s1 <= K_GV * e_ext;
			pbu_s1 <= K_BU * d_ext;
			w_s1   <= w_eff;
			h_s1   <= h_eff;
			img_s1 <= img_full;
		end
	end

	assign y_ext = signed'(SUM_W'({a_s1, 16'h0000}));
	assign sum_r = y_ext + SUM_W'(prv_s1);
	assign sum_g = y_ext - SUM_W'(pgu_s1) - SUM_W'(pgv_s1);
	assign sum_b = y_ext + SUM_W'(pbu_s1);

	always_comb begin
		cmd_d             = '0;
		cmd_d.hdr         = hdr_s1;
		cmd_d.img_bytes   = bmpenc_pkg::WORD_W'(img_s1);
		cmd_d.file_size   = bmpenc_pkg::WORD_W'(img_s1) +
			bmpenc_pkg::WORD_W'(bmpenc_pkg::HDR_BYTES);
		cmd_d.width_word  = bmpenc_pkg::WORD_W'(w_s1);
		cmd_d.height_word = bmpenc_pkg::WORD_W'(h_s1);
		cmd_d.red         = yuv_s1 ? clamp_q16(sum_r) : a_s1;
		cmd_d.green       = yuv_s1 ? clamp_q16(sum_g) : b_s1;
		cmd_d.blue        = yuv_s1 ? clamp_q16(sum_b) : c_s1;
		cmd_d.pad         = pad_s1;
		cmd_d.frame_done  = done_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s2 && valid_s1) begin
			cmd_s2 <= cmd_d;
		end
	end

	assign cmd       = cmd_s2;
	assign cmd_valid = valid_s2;

endmodule

`default_nettype wire

// File: hdl/bmpenc_queue.sv
// ----------------------------------------------------------------------------
// bmpenc_queue - command queue between front end and byte sequencer
// Small first-in first-out store of pixel commands in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpenc_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire bmpenc_pkg::cmd_t din,
	output logic                  full,
	input  wire                   pop,
	output bmpenc_pkg::cmd_t      dout,
	output logic                  empty
);

	localparam int DEPTH = bmpenc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bmpenc_pkg::cmd_t   entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

endmodule

`default_nettype wire

// File: hdl/bmpenc_back.sv
// ----------------------------------------------------------------------------
// bmpenc_back - byte sequencer of the bmp stream encoder
// Walks each queued command through its header (if flagged), pixel and padding
// bytes, one byte per cycle while the output is not stalled, into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpenc_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire bmpenc_pkg::cmd_t head,
	input  wire                   empty,
	output logic                  pop,
	bmpenc_byte_if.source         byte_out
);

	localparam int POS_W   = 6;
	localparam int C_W     = bmpenc_pkg::COMP_W;
	localparam logic [POS_W-1:0] POS_BLUE  = POS_W'(bmpenc_pkg::HDR_BYTES);
	localparam logic [POS_W-1:0] POS_GREEN = POS_W'(bmpenc_pkg::HDR_BYTES + 1);
	localparam logic [POS_W-1:0] POS_RED   = POS_W'(bmpenc_pkg::HDR_BYTES + 2);

	function automatic logic [C_W-1:0] hdr_byte(input logic [POS_W-1:0] idx,
		input bmpenc_pkg::cmd_t c);
		logic [C_W-1:0] r;
		unique case (idx)
			6'd0:    r = bmpenc_pkg::BMP_MAGIC_B;
			6'd1:    r = bmpenc_pkg::BMP_MAGIC_M;
			6'd2:    r = c.file_size[7:0];
			6'd3:    r = c.file_size[15:8];
			6'd4:    r = c.file_size[23:16];
			6'd5:    r = c.file_size[31:24];
			6'd10:   r = C_W'(bmpenc_pkg::HDR_BYTES);
			6'd14:   r = C_W'(bmpenc_pkg::INFO_BYTES);
			6'd18:   r = c.width_word[7:0];
			6'd19:   r = c.width_word[15:8];
			6'd20:   r = c.width_word[23:16];
			6'd21:   r = c.width_word[31:24];
			6'd22:   r = c.height_word[7:0];
			6'd23:   r = c.height_word[15:8];
			6'd24:   r = c.height_word[23:16];
			6'd25:   r = c.height_word[31:24];
			6'd26:   r = C_W'(1);
			6'd28:   r = C_W'(bmpenc_pkg::BITS_PER_PIXEL);
			6'd34:   r = c.img_bytes[7:0];
			6'd35:   r = c.img_bytes[15:8];
			6'd36:   r = c.img_bytes[23:16];
			6'd37:   r = c.img_bytes[31:24];
			default: r = '0;
		endcase
		return r;
	endfunction

	logic [POS_W-1:0] pos_q;
	logic             started_q;
	logic [POS_W-1:0] pos;
	logic             last;
	logic             emit;
	logic [C_W-1:0]   byte_d;

	logic             out_valid_q;
	logic [C_W-1:0]   out_byte_q;
	logic             run_last_q;
	logic             frame_end_q;

	// a command without header starts at its first pixel byte
	assign pos  = started_q ? pos_q : (head.hdr ? '0 : POS_BLUE);
	assign last = pos == (POS_RED + POS_W'(head.pad));
	assign emit = !empty && (!out_valid_q || byte_out.ready);
	assign pop  = emit && last;

	always_comb begin
		priority if (pos < POS_BLUE) begin
			byte_d = hdr_byte(pos, head);
		end else if (pos == POS_BLUE) begin
			byte_d = head.blue;
		end else if (pos == POS_GREEN) begin
			byte_d = head.green;
		end else if (pos == POS_RED) begin
			byte_d = head.red;
		end else begin
			byte_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				started_q   <= !last;
				pos_q       <= pos + POS_W'(1);
				out_valid_q <= 1'b1;
			end else if (byte_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= byte_d;
			run_last_q  <= last;
			frame_end_q <= last && head.frame_done;
		end
	end

	assign byte_out.valid     = out_valid_q;
	assign byte_out.out_byte  = out_byte_q;
	assign byte_out.run_last  = run_last_q;
	assign byte_out.frame_end = frame_end_q;

endmodule

`default_nettype wire

// File: hdl/bmpenc_checker.sv
// ----------------------------------------------------------------------------
// bmpenc_checker - port-level checks of the bmp stream encoder
// Watches the pixel input and byte output channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bmpenc_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [bmpenc_pkg::COMP_W-1:0] out_byte,
	input wire                          run_last,
	input wire                          frame_end
);

	logic seen_in_q;
	logic file_start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q    <= 1'b0;
			file_start_q <= 1'b1;
		end else begin
			if (in_valid && in_ready) begin
				seen_in_q <= 1'b1;
			end
			if (out_valid && out_ready) begin
				file_start_q <= frame_end;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
			$stable(run_last) && $stable(frame_end))
		else $error("output changed while stalled");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last)
		else $error("frame end without pixel end");

	a_file_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && file_start_q |-> out_byte == bmpenc_pkg::BMP_MAGIC_B)
		else $error("file does not open with header");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> seen_in_q)
		else $error("byte before any pixel item");

endmodule

bind yuv_to_rgb_bmp_stream_encoder_top bmpenc_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel_in.valid),
	.in_ready  (pixel_in.ready),
	.out_valid (byte_out.valid),
	.out_ready (byte_out.ready),
	.out_byte  (byte_out.out_byte),
	.run_last  (byte_out.run_last),
	.frame_end (byte_out.frame_end)
);

`default_nettype wire
